[sv/json_token_lexer_macros.svh]
// ----------------------------------------------------------------------------
// json_token_lexer_macros
// Assertion macros used by the lexer top level.
// ----------------------------------------------------------------------------
`ifndef JSON_TOKEN_LEXER_MACROS_SVH
`define JSON_TOKEN_LEXER_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define JTL_ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("lexer assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define JTL_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("lexer assertion failed");

`endif

[sv/jtl_pkg.sv]
// ----------------------------------------------------------------------------
// jtl_pkg
// Token codes, error codes, character constants and result types of the
// JSON token lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jtl_pkg;

  localparam int CharW = 21;

  // Token kinds.
  localparam logic [3:0] TK_END    = 4'd0;
  localparam logic [3:0] TK_LBRACK = 4'd1;
  localparam logic [3:0] TK_RBRACK = 4'd2;
  localparam logic [3:0] TK_LBRACE = 4'd3;
  localparam logic [3:0] TK_RBRACE = 4'd4;
  localparam logic [3:0] TK_COMMA  = 4'd5;
  localparam logic [3:0] TK_COLON  = 4'd6;
  localparam logic [3:0] TK_STRING = 4'd7;
  localparam logic [3:0] TK_NUMBER = 4'd8;
  localparam logic [3:0] TK_NULL   = 4'd9;
  localparam logic [3:0] TK_ERROR  = 4'd12;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_END_STRING = 3'd1;
  localparam logic [2:0] ERR_BAD_NULL   = 3'd2;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd5;

  // Literal kinds.
  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  // Characters.
  localparam logic [CharW-1:0] CH_LBRACK = 21'h5B;
  localparam logic [CharW-1:0] CH_RBRACK = 21'h5D;
  localparam logic [CharW-1:0] CH_LBRACE = 21'h7B;
  localparam logic [CharW-1:0] CH_RBRACE = 21'h7D;
  localparam logic [CharW-1:0] CH_COMMA  = 21'h2C;
  localparam logic [CharW-1:0] CH_COLON  = 21'h3A;
  localparam logic [CharW-1:0] CH_QUOTE  = 21'h22;
  localparam logic [CharW-1:0] CH_BSLASH = 21'h5C;
  localparam logic [CharW-1:0] CH_DOT    = 21'h2E;
  localparam logic [CharW-1:0] CH_PLUS   = 21'h2B;
  localparam logic [CharW-1:0] CH_MINUS  = 21'h2D;
  localparam logic [CharW-1:0] CH_ZERO   = 21'h30;
  localparam logic [CharW-1:0] CH_NINE   = 21'h39;
  localparam logic [CharW-1:0] CH_SPACE  = 21'h20;
  localparam logic [CharW-1:0] CH_TAB    = 21'h09;
  localparam logic [CharW-1:0] CH_CR     = 21'h0D;
  localparam logic [CharW-1:0] CH_UPPER_E = 21'h45;
  localparam logic [CharW-1:0] CH_A      = 21'h61;
  localparam logic [CharW-1:0] CH_E      = 21'h65;
  localparam logic [CharW-1:0] CH_F      = 21'h66;
  localparam logic [CharW-1:0] CH_L      = 21'h6C;
  localparam logic [CharW-1:0] CH_N      = 21'h6E;
  localparam logic [CharW-1:0] CH_R      = 21'h72;
  localparam logic [CharW-1:0] CH_S      = 21'h73;
  localparam logic [CharW-1:0] CH_T      = 21'h74;
  localparam logic [CharW-1:0] CH_U      = 21'h75;

  typedef struct packed {
    logic [3:0]       tok_kind;
    logic [CharW-1:0] char_value;
    logic             has_char;
    logic             piece_last;
    logic [2:0]       err_code;
  } result_t;

  // One queue entry: the results that one input item causes.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic result_t mk_res(input logic [3:0] kind, input logic [CharW-1:0] ch,
                                     input logic has, input logic last,
                                     input logic [2:0] err);
    result_t r;
    r.tok_kind   = kind;
    r.char_value = ch;
    r.has_char   = has;
    r.piece_last = last;
    r.err_code   = err;
    return r;
  endfunction

  function automatic logic [CharW-1:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [CharW-1:0] ch;
    ch = '0;
    case (kind)
      LIT_NULL: begin
        case (pos)
          3'd0: ch = CH_N;
          3'd1: ch = CH_U;
          3'd2: ch = CH_L;
          3'd3: ch = CH_L;
          default: ch = '0;
        endcase
      end
      LIT_TRUE: begin
        case (pos)
          3'd0: ch = CH_T;
          3'd1: ch = CH_R;
          3'd2: ch = CH_U;
          3'd3: ch = CH_E;
          default: ch = '0;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = CH_F;
          3'd1: ch = CH_A;
          3'd2: ch = CH_L;
          3'd3: ch = CH_S;
          3'd4: ch = CH_E;
          default: ch = '0;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    logic [2:0] len;
    case (kind)
      LIT_NULL: len = 3'd4;
      LIT_TRUE: len = 3'd4;
      default:  len = 3'd5;
    endcase
    return len;
  endfunction

endpackage

[sv/json_token_lexer.sv]
// ----------------------------------------------------------------------------
// json_token_lexer
// Streaming JSON tokenizer: one character in, up to two token results out.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid / in_ready    in_char_code, in_end_of_input
//  out      output     out_valid / out_ready  out_tok_kind, out_char_value,
//                                              out_has_char, out_piece_last,
//                                              out_err_code
//
// A character is accepted whenever the result queue (QueueDepth entries) has
// room; its results go into the queue, whose head entry drives the output.
// One result per cycle is delivered while out_ready is high; a character
// that closes a number and yields a token or error of its own, or an end of
// input that closes a pending token, gives two results, delivered in turn.
// Input rate is one character per cycle; it stalls only on a full queue.
// Reset is synchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_token_lexer #(
  parameter int QueueDepth = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [jtl_pkg::CharW-1:0] in_char_code,
  input  logic                      in_end_of_input,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                out_tok_kind,
  output logic [jtl_pkg::CharW-1:0] out_char_value,
  output logic                      out_has_char,
  output logic                      out_piece_last,
  output logic [2:0]                out_err_code
);
  import jtl_pkg::*;

  q_status_t q_status;
  logic      push, pop;
  entry_t    push_entry, head;
  logic      err_ok, piece_ok, zero_ok;

  jtl_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .in_end_of_input (in_end_of_input),
    .q_status        (q_status),
    .push            (push),
    .push_entry      (push_entry)
  );

  jtl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  jtl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tok_kind   (out_tok_kind),
    .out_char_value (out_char_value),
    .out_has_char   (out_has_char),
    .out_piece_last (out_piece_last),
    .out_err_code   (out_err_code)
  );

  // Well-formedness of the result currently offered.
  assign err_ok   = (out_tok_kind == TK_ERROR) || (out_err_code == ERR_NONE);
  assign piece_ok = !out_has_char ||
                    (!out_piece_last && (out_tok_kind == TK_STRING ||
                                         out_tok_kind == TK_NUMBER));
  assign zero_ok  = out_has_char || (out_char_value == '0);

`include "json_token_lexer_macros.svh"

  `JTL_ASSERT_IMPLIES(a_err_only_on_error, clk, rst_n, out_valid, err_ok)
  `JTL_ASSERT_IMPLIES(a_content_not_last, clk, rst_n, out_valid, piece_ok)
  `JTL_ASSERT_IMPLIES(a_no_char_is_zero, clk, rst_n, out_valid, zero_ok)
  `JTL_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, push && !pop, out_valid)

endmodule

[sv/jtl_front.sv]
// ----------------------------------------------------------------------------
// jtl_front
// Accepts characters, tracks the lexer mode and builds the results of each
// character as one queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtl_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [jtl_pkg::CharW-1:0] in_char_code,
  input  logic                      in_end_of_input,
  input  jtl_pkg::q_status_t        q_status,
  output logic                      push,
  output jtl_pkg::entry_t           push_entry
);
  import jtl_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_NUMBER,
    MODE_LITERAL,
    MODE_ERROR
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic       esc_r, esc_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [2:0] err_r, err_nxt;

  logic [CharW-1:0] c;
  logic [1:0]       k;
  logic             is_space, is_digit, is_numc;
  logic             accept;

  // Outcome of lexing the character from the idle mode.
  logic       idle_emit;
  result_t    idle_res;
  mode_t      idle_mode;
  logic       idle_esc;
  logic [1:0] idle_kind;
  logic [2:0] idle_pos;
  logic [2:0] idle_err;

  logic       emit;
  entry_t     ent;
  logic [2:0] pos_inc;

  assign c        = in_char_code;
  assign k        = (kind_r == 2'd3) ? LIT_FALSE : kind_r;
  assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_numc  = is_digit || c == CH_DOT || c == CH_E || c == CH_UPPER_E ||
                    c == CH_PLUS || c == CH_MINUS;
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign pos_inc  = pos_r + 3'd1;

  always_comb begin
    idle_emit = 1'b0;
    idle_res  = mk_res(TK_END, '0, 1'b0, 1'b1, ERR_NONE);
    idle_mode = MODE_IDLE;
    idle_esc  = esc_r;
    idle_kind = kind_r;
    idle_pos  = pos_r;
    idle_err  = err_r;
    if (!is_space) begin
      case (c)
        CH_LBRACK: begin idle_emit = 1'b1; idle_res.tok_kind = TK_LBRACK; end
        CH_RBRACK: begin idle_emit = 1'b1; idle_res.tok_kind = TK_RBRACK; end
        CH_LBRACE: begin idle_emit = 1'b1; idle_res.tok_kind = TK_LBRACE; end
        CH_RBRACE: begin idle_emit = 1'b1; idle_res.tok_kind = TK_RBRACE; end
        CH_COMMA:  begin idle_emit = 1'b1; idle_res.tok_kind = TK_COMMA;  end
        CH_COLON:  begin idle_emit = 1'b1; idle_res.tok_kind = TK_COLON;  end
        CH_QUOTE: begin
          idle_mode = MODE_STRING;
          idle_esc  = 1'b0;
        end
        CH_N: begin idle_mode = MODE_LITERAL; idle_kind = LIT_NULL;  idle_pos = 3'd1; end
        CH_T: begin idle_mode = MODE_LITERAL; idle_kind = LIT_TRUE;  idle_pos = 3'd1; end
        CH_F: begin idle_mode = MODE_LITERAL; idle_kind = LIT_FALSE; idle_pos = 3'd1; end
        default: begin
          idle_emit = 1'b1;
          if (is_digit || c == CH_DOT) begin
            idle_mode = MODE_NUMBER;
            idle_res  = mk_res(TK_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
          end else begin
            idle_mode = MODE_ERROR;
            idle_err  = ERR_UNEXPECTED;
            idle_res  = mk_res(TK_ERROR, '0, 1'b0, 1'b1, ERR_UNEXPECTED);
          end
        end
      endcase
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    kind_nxt = kind_r;
    pos_nxt  = pos_r;
    err_nxt  = err_r;
    emit     = 1'b0;
    ent.first  = mk_res(TK_END, '0, 1'b0, 1'b1, ERR_NONE);
    ent.second = mk_res(TK_END, '0, 1'b0, 1'b1, ERR_NONE);
    ent.two    = 1'b0;
    if (in_end_of_input) begin
      // A pending token is closed or flagged, then the end token follows.
      emit     = 1'b1;
      ent.two  = 1'b1;
      mode_nxt = MODE_IDLE;
      esc_nxt  = 1'b0;
      kind_nxt = LIT_NULL;
      pos_nxt  = 3'd0;
      err_nxt  = ERR_NONE;
      case (mode_r)
        MODE_STRING:  ent.first = mk_res(TK_ERROR, '0, 1'b0, 1'b1, ERR_END_STRING);
        MODE_NUMBER:  ent.first = mk_res(TK_NUMBER, '0, 1'b0, 1'b1, ERR_NONE);
        MODE_LITERAL: ent.first = mk_res(TK_ERROR, '0, 1'b0, 1'b1,
                                         ERR_BAD_NULL + {1'b0, k});
        default:      ent.two   = 1'b0;
      endcase
    end else begin
      case (mode_r)
        MODE_STRING: begin
          emit = 1'b1;
          ent.first = mk_res(TK_STRING, c, 1'b1, 1'b0, ERR_NONE);
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (c == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (c == CH_QUOTE) begin
            mode_nxt  = MODE_IDLE;
            ent.first = mk_res(TK_STRING, '0, 1'b0, 1'b1, ERR_NONE);
          end
        end
        MODE_NUMBER: begin
          emit = 1'b1;
          if (is_numc) begin
            ent.first = mk_res(TK_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
          end else begin
            // The closing character is lexed again from idle in the same step.
            ent.first  = mk_res(TK_NUMBER, '0, 1'b0, 1'b1, ERR_NONE);
            ent.second = idle_res;
            ent.two    = idle_emit;
            mode_nxt   = idle_mode;
            esc_nxt    = idle_esc;
            kind_nxt   = idle_kind;
            pos_nxt    = idle_pos;
            err_nxt    = idle_err;
          end
        end
        MODE_LITERAL: begin
          if (pos_r < lit_len(k) && c == lit_char(k, pos_r)) begin
            pos_nxt = pos_inc;
            if (pos_inc == lit_len(k)) begin
              emit      = 1'b1;
              ent.first = mk_res(TK_NULL + {2'b00, k}, '0, 1'b0, 1'b1, ERR_NONE);
              mode_nxt  = MODE_IDLE;
              pos_nxt   = 3'd0;
            end
          end else begin
            emit      = 1'b1;
            pos_nxt   = 3'd0;
            mode_nxt  = MODE_ERROR;
            err_nxt   = ERR_BAD_NULL + {1'b0, k};
            ent.first = mk_res(TK_ERROR, '0, 1'b0, 1'b1, ERR_BAD_NULL + {1'b0, k});
          end
        end
        MODE_ERROR: begin
          emit      = 1'b1;
          ent.first = mk_res(TK_ERROR, '0, 1'b0, 1'b1, err_r);
        end
        default: begin
          emit      = idle_emit;
          ent.first = idle_res;
          mode_nxt  = idle_mode;
          esc_nxt   = idle_esc;
          kind_nxt  = idle_kind;
          pos_nxt   = idle_pos;
          err_nxt   = idle_err;
        end
      endcase
    end
  end

  assign push       = accept && emit;
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      esc_r  <= 1'b0;
      kind_r <= LIT_NULL;
      pos_r  <= 3'd0;
      err_r  <= ERR_NONE;
    end else if (accept) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      kind_r <= kind_nxt;
      pos_r  <= pos_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

[sv/jtl_queue.sv]
// ----------------------------------------------------------------------------
// jtl_queue
// Short first-in first-out queue of result entries between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtl_queue #(
  parameter int Depth = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jtl_pkg::entry_t     push_entry,
  input  logic                pop,
  output jtl_pkg::entry_t     head,
  output jtl_pkg::q_status_t  status
);
  import jtl_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          slots_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_pop;

  assign status.full  = (cnt_r == FullCnt);
  assign status.empty = (cnt_r == '0);
  assign head         = slots_r[rd_ptr_r];
  assign do_pop       = pop && !status.empty;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] q;
    q = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + CntW'(1);
        2'b01:   cnt_r <= cnt_r - CntW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[sv/jtl_back.sv]
// ----------------------------------------------------------------------------
// jtl_back
// Delivers the results of the head queue entry one result at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtl_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  jtl_pkg::entry_t           head,
  input  jtl_pkg::q_status_t        q_status,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                out_tok_kind,
  output logic [jtl_pkg::CharW-1:0] out_char_value,
  output logic                      out_has_char,
  output logic                      out_piece_last,
  output logic [2:0]                out_err_code
);
  import jtl_pkg::*;

  logic    second_r;
  result_t cur;
  logic    taken;

  assign out_valid      = !q_status.empty;
  assign cur            = second_r ? head.second : head.first;
  assign out_tok_kind   = cur.tok_kind;
  assign out_char_value = cur.char_value;
  assign out_has_char   = cur.has_char;
  assign out_piece_last = cur.piece_last;
  assign out_err_code   = cur.err_code;
  assign taken          = out_valid && out_ready;
  // The entry leaves once its last result is taken.
  assign pop            = taken && (second_r || !head.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else if (taken) begin
      second_r <= !second_r && head.two;
    end
  end

endmodule
